// ===== rtl/srag_pkg.sv =====
// Shared widths, register indexes and types of the scanline remap address generator.
`default_nettype none

package srag_pkg;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd4;

  // Register and field widths.
  localparam int unsigned IN_DIM_W  = 13;
  localparam int unsigned OUT_DIM_W = 11;
  localparam int unsigned BPP_W     = 3;
  localparam int unsigned ROW_IDX_W = 10;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned SRC_W     = 12;
  localparam int unsigned ADDR_W    = 26;
  localparam int unsigned SROW_W    = 16;
  localparam int unsigned FIX_W     = 32;

  // Reset values of the configuration registers.
  localparam logic [IN_DIM_W-1:0]  IN_WIDTH_RST   = 13'd640;
  localparam logic [IN_DIM_W-1:0]  IN_HEIGHT_RST  = 13'd480;
  localparam logic [OUT_DIM_W-1:0] OUT_WIDTH_RST  = 11'd256;
  localparam logic [OUT_DIM_W-1:0] OUT_HEIGHT_RST = 11'd256;
  localparam logic [BPP_W-1:0]     BPP_RST        = 3'd1;

  // One row entry of the remap table.
  typedef struct packed {
    logic signed [SROW_W-1:0] src_row;
    logic signed [FIX_W-1:0]  x_start;
    logic signed [FIX_W-1:0]  x_step;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;    // write the table entry of the current input transfer
    logic rd_en;    // read the table entry of the current output row
    logic eval_en;  // evaluate the pixel and advance the walk state
    logic mul_en;   // form the row offset product
    logic send_en;  // load the output register
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/srag_if.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface srag_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   action;
  logic [srag_pkg::ROW_IDX_W-1:0]         row_index;
  logic signed [srag_pkg::SROW_W-1:0]     entry_src_row;
  logic signed [srag_pkg::FIX_W-1:0]      entry_x_start;
  logic signed [srag_pkg::FIX_W-1:0]      entry_x_step;

  modport source (
    output valid, action, row_index, entry_src_row, entry_x_start, entry_x_step,
    input  ready
  );
  modport sink (
    input  valid, action, row_index, entry_src_row, entry_x_start, entry_x_step,
    output ready
  );
endinterface

interface srag_out_if;
  logic                          valid;
  logic                          ready;
  logic [srag_pkg::POS_W-1:0]    out_row;
  logic [srag_pkg::POS_W-1:0]    out_col;
  logic                          missing;
  logic [srag_pkg::SRC_W-1:0]    src_x;
  logic [srag_pkg::SRC_W-1:0]    src_y;
  logic [srag_pkg::ADDR_W-1:0]   byte_address;
  logic                          last_of_row;
  logic                          last_of_frame;

  modport source (
    output valid, out_row, out_col, missing, src_x, src_y, byte_address,
           last_of_row, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, out_row, out_col, missing, src_x, src_y, byte_address,
           last_of_row, last_of_frame,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/srag_ctrl.sv =====
// Controller state machine: accepts transfers and sequences the datapath steps.
`default_nettype none

module srag_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_action_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output srag_pkg::dp_cmd_t      cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_MULT = 2'd2;
  localparam logic [1:0] ST_SEND = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_action_i) begin
            cmd_o.rd_en = 1'b1;
            state_d     = ST_EVAL;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      ST_EVAL: begin
        cmd_o.eval_en = 1'b1;
        state_d       = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mul_en = 1'b1;
        state_d      = ST_SEND;
      end
      ST_SEND: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.send_en = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/srag_dp.sv =====
// Datapath: configuration registers, row table memory, x walk and address arithmetic.
`default_nettype none

module srag_dp #(
  parameter int unsigned MAX_OUT_ROWS = 1024,
  parameter int unsigned MAX_OUT_COLS = 1024,
  parameter int unsigned MAX_IN_DIM   = 4096,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [srag_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [srag_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire srag_pkg::dp_cmd_t                    cmd_i,
  input  wire logic [srag_pkg::ROW_IDX_W-1:0]       row_index_i,
  input  wire logic signed [srag_pkg::SROW_W-1:0]   entry_src_row_i,
  input  wire logic signed [srag_pkg::FIX_W-1:0]    entry_x_start_i,
  input  wire logic signed [srag_pkg::FIX_W-1:0]    entry_x_step_i,
  output logic [srag_pkg::POS_W-1:0]                out_row_o,
  output logic [srag_pkg::POS_W-1:0]                out_col_o,
  output logic                                      missing_o,
  output logic [srag_pkg::SRC_W-1:0]                src_x_o,
  output logic [srag_pkg::SRC_W-1:0]                src_y_o,
  output logic [srag_pkg::ADDR_W-1:0]               byte_address_o,
  output logic                                      last_of_row_o,
  output logic                                      last_of_frame_o
);

  localparam int unsigned RW   = $clog2(MAX_OUT_ROWS);
  localparam int unsigned CW   = $clog2(MAX_OUT_COLS);
  localparam int unsigned OHC  = $clog2(MAX_OUT_ROWS + 1);
  localparam int unsigned OWC  = $clog2(MAX_OUT_COLS + 1);
  localparam int unsigned OH_W = (srag_pkg::OUT_DIM_W > OHC) ? srag_pkg::OUT_DIM_W : OHC;
  localparam int unsigned OW_W = (srag_pkg::OUT_DIM_W > OWC) ? srag_pkg::OUT_DIM_W : OWC;
  localparam int unsigned XI_W = srag_pkg::FIX_W - FRAC_BITS;
  localparam int unsigned CMP_A = (XI_W > srag_pkg::IN_DIM_W) ? XI_W : srag_pkg::IN_DIM_W;
  localparam int unsigned CMP_W = ((CMP_A > srag_pkg::SROW_W) ? CMP_A : srag_pkg::SROW_W) + 1;
  localparam int unsigned DW   = srag_pkg::IN_DIM_W;
  localparam int unsigned FW   = srag_pkg::FIX_W;
  localparam logic signed [FW-1:0] ROUND_BIAS = FW'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [FW-1:0] FIX_MAX = {1'b0, {(FW-1){1'b1}}};
  localparam logic signed [FW-1:0] FIX_MIN = {1'b1, {(FW-1){1'b0}}};

  // Configuration registers.
  logic [DW-1:0]                    in_width_q, in_height_q;
  logic [srag_pkg::OUT_DIM_W-1:0]   out_width_q, out_height_q;
  logic [srag_pkg::BPP_W-1:0]       bpp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_width_q   <= srag_pkg::IN_WIDTH_RST;
      in_height_q  <= srag_pkg::IN_HEIGHT_RST;
      out_width_q  <= srag_pkg::OUT_WIDTH_RST;
      out_height_q <= srag_pkg::OUT_HEIGHT_RST;
      bpp_q        <= srag_pkg::BPP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srag_pkg::CFG_IN_WIDTH:   in_width_q   <= cfg_wdata_i[DW-1:0];
        srag_pkg::CFG_IN_HEIGHT:  in_height_q  <= cfg_wdata_i[DW-1:0];
        srag_pkg::CFG_OUT_WIDTH:  out_width_q  <= cfg_wdata_i[srag_pkg::OUT_DIM_W-1:0];
        srag_pkg::CFG_OUT_HEIGHT: out_height_q <= cfg_wdata_i[srag_pkg::OUT_DIM_W-1:0];
        srag_pkg::CFG_BPP:        bpp_q        <= cfg_wdata_i[srag_pkg::BPP_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped working sizes.
  logic [DW-1:0]                  iw, ih;
  logic [OW_W-1:0]                ow;
  logic [OH_W-1:0]                oh;
  logic [srag_pkg::BPP_W-1:0]     bpp;

  always_comb begin
    iw = (32'(in_width_q) > MAX_IN_DIM) ? DW'(MAX_IN_DIM) : in_width_q;
    ih = (32'(in_height_q) > MAX_IN_DIM) ? DW'(MAX_IN_DIM) : in_height_q;
    if (out_width_q == '0) begin
      ow = OW_W'(1);
    end else if (32'(out_width_q) > MAX_OUT_COLS) begin
      ow = OW_W'(MAX_OUT_COLS);
    end else begin
      ow = OW_W'(out_width_q);
    end
    if (out_height_q == '0) begin
      oh = OH_W'(1);
    end else if (32'(out_height_q) > MAX_OUT_ROWS) begin
      oh = OH_W'(MAX_OUT_ROWS);
    end else begin
      oh = OH_W'(out_height_q);
    end
    if (bpp_q == '0) begin
      bpp = srag_pkg::BPP_W'(1);
    end else if (bpp_q > srag_pkg::BPP_W'(4)) begin
      bpp = srag_pkg::BPP_W'(4);
    end else begin
      bpp = bpp_q;
    end
  end

  // Row table memory, one entry per output row.
  srag_pkg::entry_t table_mem [MAX_OUT_ROWS];
  srag_pkg::entry_t rd_q;
  srag_pkg::entry_t wr_entry;
  logic             load_ok;
  logic [RW-1:0]    row_q, row_d;
  logic [CW-1:0]    col_q, col_d;

  assign load_ok  = (32'(row_index_i) < MAX_OUT_ROWS);
  assign wr_entry = '{src_row: entry_src_row_i, x_start: entry_x_start_i,
                      x_step: entry_x_step_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && load_ok) begin
      table_mem[RW'(row_index_i)] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rd_q <= table_mem[row_q];
    end
  end

  // Pixel evaluation.
  logic signed [FW-1:0]    acc_q, acc_d, acc_cur, biased;
  logic                    past_q, past_d, past_cur;
  logic signed [XI_W-1:0]  xi;
  logic signed [CMP_W-1:0] xi_ext, iw_ext, ih_ext, srow_ext;
  logic signed [FW:0]      acc_sum;
  logic                    row_bad, edge_hit, miss, lr, lf;
  logic [OW_W-1:0]         col_inc;
  logic [OH_W-1:0]         row_inc;
  logic [DW-1:0]           sx, sy;

  always_comb begin
    acc_cur  = (col_q == '0) ? rd_q.x_start : acc_q;
    past_cur = (col_q == '0) ? 1'b0 : past_q;
    // Bias negative values so the arithmetic shift truncates toward zero.
    biased   = acc_cur + (acc_cur[FW-1] ? ROUND_BIAS : '0);
    xi       = biased[FW-1:FRAC_BITS];
    xi_ext   = CMP_W'(xi);
    srow_ext = CMP_W'(rd_q.src_row);
    iw_ext   = $signed(CMP_W'(iw));
    ih_ext   = $signed(CMP_W'(ih));
    row_bad  = srow_ext[CMP_W-1] || (srow_ext >= ih_ext);
    edge_hit = !row_bad && (past_cur || (xi_ext >= iw_ext));
    miss     = row_bad || edge_hit || xi_ext[CMP_W-1];
    past_d   = past_cur || edge_hit;
    sx       = miss ? '0 : xi_ext[DW-1:0];
    sy       = miss ? '0 : srow_ext[DW-1:0];

    acc_sum = {acc_cur[FW-1], acc_cur} + {rd_q.x_step[FW-1], rd_q.x_step};
    if (acc_sum[FW] != acc_sum[FW-1]) begin
      acc_d = acc_sum[FW] ? FIX_MIN : FIX_MAX;
    end else begin
      acc_d = acc_sum[FW-1:0];
    end

    col_inc = OW_W'(col_q) + OW_W'(1);
    row_inc = OH_W'(row_q) + OH_W'(1);
    lr      = (col_inc >= ow);
    lf      = lr && (row_inc >= oh);
    if (lr) begin
      col_d = '0;
      row_d = lf ? '0 : RW'(row_inc);
    end else begin
      col_d = CW'(col_inc);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      acc_q  <= '0;
      past_q <= 1'b0;
    end else if (cmd_i.eval_en) begin
      row_q  <= row_d;
      col_q  <= col_d;
      acc_q  <= acc_d;
      past_q <= past_d;
    end
  end

  // Evaluated pixel, then the row offset product.
  logic [srag_pkg::POS_W-1:0]  s_row_q, s_col_q;
  logic                        s_miss_q, s_lr_q, s_lf_q;
  logic [DW-1:0]               s_sx_q, s_sy_q;
  logic [2*DW-1:0]             prod_q;
  logic [srag_pkg::ADDR_W-1:0] lin, addr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval_en) begin
      s_row_q  <= srag_pkg::POS_W'(row_q);
      s_col_q  <= srag_pkg::POS_W'(col_q);
      s_miss_q <= miss;
      s_sx_q   <= sx;
      s_sy_q   <= sy;
      s_lr_q   <= lr;
      s_lf_q   <= lf;
    end
    if (cmd_i.mul_en) begin
      prod_q <= (2*DW)'(s_sy_q) * (2*DW)'(iw);
    end
  end

  // A missing pixel carries zero coordinates, so its address comes out zero.
  always_comb begin
    lin = srag_pkg::ADDR_W'(prod_q) + srag_pkg::ADDR_W'(s_sx_q);
    case (bpp)
      srag_pkg::BPP_W'(1): addr = lin;
      srag_pkg::BPP_W'(2): addr = lin << 1;
      srag_pkg::BPP_W'(3): addr = lin + (lin << 1);
      default:             addr = lin << 2;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.send_en) begin
      out_row_o       <= s_row_q;
      out_col_o       <= s_col_q;
      missing_o       <= s_miss_q;
      src_x_o         <= s_sx_q[srag_pkg::SRC_W-1:0];
      src_y_o         <= s_sy_q[srag_pkg::SRC_W-1:0];
      byte_address_o  <= addr;
      last_of_row_o   <= s_lr_q;
      last_of_frame_o <= s_lf_q;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/scanline_remap_address_generator.sv =====
// A pixel transfer passes through the table read, evaluation, row offset multiply and
// output load steps of the controller; the output load waits while the output register
// is full. No new transfer is accepted until the sequence ends; table loads stay idle.
// The next transfer is accepted while a finished result waits in the output register.
// Reset clears the walk position, accumulator, controller and configuration
// registers; the row table holds no reset value and must be loaded before use.
`default_nettype none

module scanline_remap_address_generator #(
  parameter int unsigned MAX_OUT_ROWS = 1024,
  parameter int unsigned MAX_OUT_COLS = 1024,
  parameter int unsigned MAX_IN_DIM   = 4096,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [srag_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [srag_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  srag_in_if.sink                               in_i,
  srag_out_if.source                            out_o
);

  srag_pkg::dp_cmd_t cmd;

  srag_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  srag_dp #(
    .MAX_OUT_ROWS (MAX_OUT_ROWS),
    .MAX_OUT_COLS (MAX_OUT_COLS),
    .MAX_IN_DIM   (MAX_IN_DIM),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .cmd_i           (cmd),
    .row_index_i     (in_i.row_index),
    .entry_src_row_i (in_i.entry_src_row),
    .entry_x_start_i (in_i.entry_x_start),
    .entry_x_step_i  (in_i.entry_x_step),
    .out_row_o       (out_o.out_row),
    .out_col_o       (out_o.out_col),
    .missing_o       (out_o.missing),
    .src_x_o         (out_o.src_x),
    .src_y_o         (out_o.src_y),
    .byte_address_o  (out_o.byte_address),
    .last_of_row_o   (out_o.last_of_row),
    .last_of_frame_o (out_o.last_of_frame)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench of the scanline remap address generator.
`timescale 1ns / 100ps

module testbench;

  localparam int     TABLE_ROWS = 1024;
  localparam longint MAX_COLS   = 1024;
  localparam longint MAX_IN     = 4096;
  localparam int     FRAC       = 16;
  localparam longint ACC_MAX    = 64'sd2147483647;
  localparam longint ACC_MIN    = -64'sd2147483648;
  localparam int     STALL_LIMIT = 4000;
  localparam int     HOLD_CYCLES = 250;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PIXEL = 1'b1
  } action_e;

  typedef struct packed {
    action_e                         action;
    logic [srag_pkg::ROW_IDX_W-1:0]  row_index;
    logic [srag_pkg::SROW_W-1:0]     src_row;
    logic [srag_pkg::FIX_W-1:0]      x_start;
    logic [srag_pkg::FIX_W-1:0]      x_step;
  } item_t;

  typedef struct packed {
    logic [srag_pkg::POS_W-1:0]  out_row;
    logic [srag_pkg::POS_W-1:0]  out_col;
    logic                        missing;
    logic [srag_pkg::SRC_W-1:0]  src_x;
    logic [srag_pkg::SRC_W-1:0]  src_y;
    logic [srag_pkg::ADDR_W-1:0] byte_address;
    logic                        last_of_row;
    logic                        last_of_frame;
  } pixel_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [srag_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [srag_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  srag_in_if  in_bus ();
  srag_out_if out_bus ();

  scanline_remap_address_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Register copies, as written.
  int unsigned reg_in_width  = srag_pkg::IN_WIDTH_RST;
  int unsigned reg_in_height = srag_pkg::IN_HEIGHT_RST;
  int unsigned reg_out_width = srag_pkg::OUT_WIDTH_RST;
  int unsigned reg_out_height = srag_pkg::OUT_HEIGHT_RST;
  int unsigned reg_bpp       = srag_pkg::BPP_RST;

  // Predicted block state.
  srag_pkg::entry_t row_table [TABLE_ROWS];
  int     walk_row = 0;
  int     walk_col = 0;
  longint x_acc = 0;
  bit     past_edge = 1'b0;

  // Stimulus side: walk position as the generator sees it, and rows loaded so far.
  int gen_row = 0;
  int gen_col = 0;
  bit row_loaded [TABLE_ROWS];

  item_t  pending_items [$];
  pixel_t expected_pixels [$];
  item_t  offered;

  int mismatches = 0;
  int pixels_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm = 1'b0;
  int quiet_cycles = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint out_cols();
    return clamp(reg_out_width, 1, MAX_COLS);
  endfunction

  function automatic longint out_rows();
    return clamp(reg_out_height, 1, TABLE_ROWS);
  endfunction

  function automatic longint in_cols();
    return clamp(reg_in_width, 0, MAX_IN);
  endfunction

  function automatic longint in_rows();
    return clamp(reg_in_height, 0, MAX_IN);
  endfunction

  // Moves a walk position one pixel on; a position already past a shrunken size
  // ends its row or frame at once.
  function automatic void step_walk(inout int row, inout int col, output bit lr,
                                    output bit lf);
    lr = (col + 1) >= out_cols();
    lf = lr && (row + 1) >= out_rows();
    if (lr) begin
      col = 0;
      row = lf ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endfunction

  function automatic void store_entry(item_t it);
    row_table[it.row_index] = '{src_row: it.src_row, x_start: it.x_start,
                                x_step: it.x_step};
  endfunction

  function automatic pixel_t remap_pixel();
    srag_pkg::entry_t e;
    pixel_t r;
    longint srow, xi, sum, iw, ih, addr;
    bit lr, lf;
    e = row_table[walk_row];
    iw = in_cols();
    ih = in_rows();
    if (walk_col == 0) begin
      x_acc = $signed(e.x_start);
      past_edge = 1'b0;
    end
    srow = $signed(e.src_row);
    // Truncation toward zero, not floor.
    xi = (x_acc >= 0) ? (x_acc >>> FRAC) : -((-x_acc) >>> FRAC);
    r = '0;
    r.out_row = walk_row[srag_pkg::POS_W-1:0];
    r.out_col = walk_col[srag_pkg::POS_W-1:0];
    if (srow < 0 || srow >= ih) begin
      r.missing = 1'b1;
    end else if (past_edge || xi >= iw) begin
      past_edge = 1'b1;
      r.missing = 1'b1;
    end else if (xi < 0) begin
      r.missing = 1'b1;
    end else begin
      addr = (srow * iw + xi) * clamp(reg_bpp, 1, 4);
      r.src_x = xi[srag_pkg::SRC_W-1:0];
      r.src_y = srow[srag_pkg::SRC_W-1:0];
      r.byte_address = addr[srag_pkg::ADDR_W-1:0];
    end
    sum = x_acc + longint'($signed(e.x_step));
    x_acc = clamp(sum, ACC_MIN, ACC_MAX);
    step_walk(walk_row, walk_col, lr, lf);
    r.last_of_row = lr;
    r.last_of_frame = lf;
    return r;
  endfunction

  function automatic string show(pixel_t p);
    return $sformatf("row %0d col %0d miss %0d sx %0d sy %0d addr 0x%0h lr %0d lf %0d",
                     p.out_row, p.out_col, p.missing, p.src_x, p.src_y,
                     p.byte_address, p.last_of_row, p.last_of_frame);
  endfunction

  function automatic void queue_load(int row, logic [srag_pkg::SROW_W-1:0] src,
                                     logic [srag_pkg::FIX_W-1:0] start,
                                     logic [srag_pkg::FIX_W-1:0] stp);
    item_t it;
    it.action = ACT_LOAD;
    it.row_index = row[srag_pkg::ROW_IDX_W-1:0];
    it.src_row = src;
    it.x_start = start;
    it.x_step = stp;
    row_loaded[row] = 1'b1;
    pending_items.push_back(it);
  endfunction

  // A table entry that mostly lands inside the source image and sweeps across it.
  function automatic void queue_shaped_load(int row);
    longint iw, ih, src, start, stp;
    int unsigned pick;
    iw = in_cols();
    ih = in_rows();
    pick = $urandom_range(0, 9);
    if (pick == 0) src = $urandom_range(0, 65535);
    else if (pick == 1) src = ih + $urandom_range(0, 2);
    else src = (ih > 0) ? $urandom_range(0, 32'(ih - 1)) : 0;
    start = (longint'($urandom_range(0, 32'(iw + 8))) - 4) * 65536
            + $urandom_range(0, 65535) - 32768;
    stp = ((iw * 65536) / out_cols()) * $urandom_range(40, 160) / 100;
    if ($urandom_range(0, 4) == 0) stp = -stp;
    if ($urandom_range(0, 9) == 0) start = $urandom;
    if ($urandom_range(0, 9) == 0) stp = $urandom;
    queue_load(row, src[srag_pkg::SROW_W-1:0], start[srag_pkg::FIX_W-1:0],
               stp[srag_pkg::FIX_W-1:0]);
  endfunction

  function automatic void queue_pixel(bit allow_reload);
    item_t it;
    bit lr, lf;
    if (!row_loaded[gen_row] || (allow_reload && gen_col == 0 && $urandom_range(0, 1)))
      queue_shaped_load(gen_row);
    it.action = ACT_PIXEL;
    it.row_index = srag_pkg::ROW_IDX_W'($urandom);
    it.src_row = srag_pkg::SROW_W'($urandom);
    it.x_start = $urandom;
    it.x_step = $urandom;
    pending_items.push_back(it);
    step_walk(gen_row, gen_col, lr, lf);
  endfunction

  function automatic void queue_random(int count);
    int unsigned pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)
        queue_load(int'($urandom_range(0, TABLE_ROWS - 1)), srag_pkg::SROW_W'($urandom),
                   $urandom, $urandom);
      else if (pick < 18)
        queue_shaped_load($urandom_range(0, 1) ? gen_row
                                               : int'($urandom_range(0, TABLE_ROWS - 1)));
      else
        queue_pixel(1'b1);
    end
  endfunction

  // Waits until every item is in and every result is out, then lets the pipeline settle.
  task automatic drain();
    while (pending_items.size() != 0 || in_bus.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [srag_pkg::CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value[srag_pkg::CFG_DATA_W-1:0];
    case (idx)
      srag_pkg::CFG_IN_WIDTH:   reg_in_width = value & 'h1FFF;
      srag_pkg::CFG_IN_HEIGHT:  reg_in_height = value & 'h1FFF;
      srag_pkg::CFG_OUT_WIDTH:  reg_out_width = value & 'h7FF;
      srag_pkg::CFG_OUT_HEIGHT: reg_out_height = value & 'h7FF;
      srag_pkg::CFG_BPP:        reg_bpp = value & 'h7;
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned iw, int unsigned ih, int unsigned ow,
                            int unsigned oh, int unsigned bpp);
    drain();
    write_reg(srag_pkg::CFG_IN_WIDTH, iw);
    write_reg(srag_pkg::CFG_IN_HEIGHT, ih);
    write_reg(srag_pkg::CFG_OUT_WIDTH, ow);
    write_reg(srag_pkg::CFG_OUT_HEIGHT, oh);
    write_reg(srag_pkg::CFG_BPP, bpp);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    int unsigned iw, ih, ow, oh;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frame of six rows of three pixels over a 16 x 8 source.
    set_config(16, 8, 3, 6, 3);
    queue_load(0, 16'd7, 32'hFFFF_8000, 32'h0007_C000);   // -0.5 truncates to 0, ends at 15
    queue_load(1, 16'h8000, 32'h7FFF_FFFF, 32'hFFFF_FFFF); // source row below zero
    queue_load(2, 16'd0, 32'hFFFE_0000, 32'h0009_0000);   // negative x, then right edge
    queue_load(3, 16'd3, 32'h0011_0000, 32'hFFFD_0000);   // edge sticks as x comes back
    queue_load(4, 16'd8, 32'h7FFF_0000, 32'h7FFF_FFFF);   // source row equal to height
    queue_load(5, 16'd2, 32'h0005_0000, 32'h8000_0000);   // accumulator hits the minimum
    for (int k = 0; k < 18; k++) queue_pixel(1'b0);

    set_config(8191, 8191, 0, 0, 0);
    queue_random(60);
    set_config(0, 4096, 2047, 2, 7);
    queue_random(60);
    set_config(4096, 4096, 1024, 1024, 4);
    queue_random(80);
    set_config(2, 2, 2, 2, 1);
    queue_random(60);

    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 4))
        0: iw = 2;
        1: iw = 4096;
        default: iw = $urandom_range(2, 4096);
      endcase
      case ($urandom_range(0, 4))
        0: ih = $urandom_range(0, 1) ? 2 : 4096;
        default: ih = $urandom_range(2, 4096);
      endcase
      ow = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(2, 24);
      oh = ($urandom_range(0, 7) == 0) ? 1024 : $urandom_range(2, 10);
      set_config(iw, ih, ow, oh, $urandom_range(0, 7));
      calm = (p == 4);
      queue_random(115);
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // Sender: holds an offered item until its transfer, then may idle before the next.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
      in_bus.action <= ACT_LOAD;
      in_bus.row_index <= '0;
      in_bus.entry_src_row <= '0;
      in_bus.entry_x_start <= '0;
      in_bus.entry_x_step <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (offered.action == ACT_PIXEL) expected_pixels.push_back(remap_pixel());
        else store_entry(offered);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 11)) begin
          offered = pending_items.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.action <= offered.action;
          in_bus.row_index <= offered.row_index;
          in_bus.entry_src_row <= offered.src_row;
          in_bus.entry_x_start <= offered.x_start;
          in_bus.entry_x_step <= offered.x_step;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer and stalls at random, once for a long stretch.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t got, want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.out_row, out_bus.out_col, out_bus.missing, out_bus.src_x,
               out_bus.src_y, out_bus.byte_address, out_bus.last_of_row,
               out_bus.last_of_frame};
        pixels_seen++;
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: %s", show(got));
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch\n  expected %s\n  actual   %s", show(want), show(got));
          end
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else if (!hold_done && pixels_seen >= 300 && in_bus.valid) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= calm || $urandom_range(0, 99) >= 11;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles", quiet_cycles);
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule
